// ===== design/looping_random_shift_sequencer_unit_defines.svh =====
// Assertion macros for the looping random shift sequencer.
// Included by the top level; depends on nothing else.
`ifndef LOOPING_RANDOM_SHIFT_SEQUENCER_UNIT_DEFINES_SVH
`define LOOPING_RANDOM_SHIFT_SEQUENCER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LRSS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LRSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/lrss_pkg.sv =====
// Types, operation codes and knob tables of the looping random shift sequencer.
// Used by lrss_step and the top level; depends on nothing else.
package lrss_pkg;

    typedef enum logic [2:0] {
        OP_CLOCK         = 3'd0,
        OP_ADJUST_CHANCE = 3'd1,
        OP_ADJUST_LENGTH = 3'd2,
        OP_ADJUST_RANGE  = 3'd3,
        OP_RESTART       = 3'd4
    } op_t;

    localparam logic [2:0] CHANCE_MAX          = 3'd4;
    localparam logic [2:0] LENGTH_MAX          = 3'd6;
    localparam logic [2:0] RANGE_MAX           = 3'd4;
    localparam logic [2:0] CHANCE_RESET        = 3'd1;
    localparam logic [2:0] LENGTH_RESET        = 3'd6;
    localparam logic [2:0] RANGE_RESET         = 3'd4;
    localparam logic [2:0] CHANCE_LOCKED_INDEX = 3'd2;

    localparam logic [6:0] GEN_MUL = 7'd109;
    localparam logic [6:0] GEN_ADD = 7'd89;
    localparam logic [7:0] GEN_MOD = 8'd251;

    localparam logic [2:0] ADDR_SEED = 3'd0;

    // The generator is kept reduced below the modulus, so eight bits suffice.
    typedef struct packed {
        logic [7:0]  generator;
        logic [15:0] pattern;
        logic [2:0]  chance_index;
        logic [2:0]  length_index;
        logic [2:0]  range_index;
    } state_t;

    typedef struct packed {
        logic [4:0] loop_length;
        logic [4:0] value;
    } result_t;

    function automatic logic [4:0] length_of(input logic [2:0] idx);
        logic [4:0] len;
        case (idx)
            3'd0:    len = 5'd2;
            3'd1:    len = 5'd3;
            3'd2:    len = 5'd4;
            3'd3:    len = 5'd5;
            3'd4:    len = 5'd8;
            3'd5:    len = 5'd12;
            default: len = 5'd16;
        endcase
        return len;
    endfunction

    // Mask is the chance minus one; the locked entry is handled by the caller.
    function automatic logic [3:0] chance_mask(input logic [2:0] idx);
        logic [3:0] mask;
        case (idx)
            3'd0:    mask = 4'd1;
            3'd1:    mask = 4'd3;
            3'd2:    mask = 4'd15;
            3'd3:    mask = 4'd7;
            default: mask = 4'd15;
        endcase
        return mask;
    endfunction

    function automatic logic [2:0] shift_of(input logic [2:0] idx);
        logic [2:0] sh;
        case (idx)
            3'd0:    sh = 3'd7;
            3'd1:    sh = 3'd6;
            3'd2:    sh = 3'd5;
            3'd3:    sh = 3'd4;
            default: sh = 3'd3;
        endcase
        return sh;
    endfunction

endpackage

// ===== design/lrss_step.sv =====
// Next-state and result logic for one item of the looping random shift sequencer.
// Depends on lrss_pkg.
module lrss_step (
    input  lrss_pkg::state_t  st,
    input  logic [2:0]        op,
    input  logic signed [7:0] delta,
    input  logic [15:0]       seed,
    output lrss_pkg::state_t  st_next,
    output lrss_pkg::result_t res
);
    import lrss_pkg::*;

    // Reduces a 16-bit value modulo 251 using 256 = 5 (mod 251).
    function automatic logic [7:0] mod251(input logic [15:0] x);
        logic [10:0] s1;
        logic [8:0]  s2;
        logic [8:0]  s3;
        s1 = {3'd0, x[15:8]} * 11'd5 + {3'd0, x[7:0]};
        s2 = {6'd0, s1[10:8]} * 9'd5 + {1'b0, s1[7:0]};
        s3 = (s2 >= {1'b0, GEN_MOD}) ? (s2 - {1'b0, GEN_MOD}) : s2;
        return s3[7:0];
    endfunction

    function automatic logic [2:0] adjust(input logic [2:0] cur,
                                          input logic signed [7:0] d,
                                          input logic [2:0] bound);
        logic signed [9:0] sum;
        logic [2:0]        r;
        sum = $signed({7'd0, cur}) + 10'(d);
        r = cur;
        if (sum >= 10'sd0 && sum <= $signed({7'd0, bound}))
        begin
            r = sum[2:0];
        end
        return r;
    endfunction

    logic [4:0]  len;
    logic [3:0]  tap;
    logic        locked;
    logic [15:0] prod;
    logic [7:0]  gen_adv;
    logic        flip;
    logic        in_bit;
    logic [15:0] pattern_clk;
    logic [7:0]  low_shifted;

    always_comb
    begin
        len         = length_of(st.length_index);
        tap         = 4'(len - 5'd1);
        locked      = (st.chance_index == CHANCE_LOCKED_INDEX);
        prod        = {8'd0, st.generator} * {9'd0, GEN_MUL} + {9'd0, GEN_ADD};
        gen_adv     = mod251(prod);
        flip        = !locked && ((gen_adv[3:0] & chance_mask(st.chance_index)) == 4'd0);
        in_bit      = st.pattern[tap] ^ flip;
        pattern_clk = {st.pattern[14:0], in_bit};
        low_shifted = pattern_clk[7:0] >> shift_of(st.range_index);

        st_next   = st;
        res.value = 5'd0;
        case (op_t'(op))
            OP_CLOCK:
            begin
                st_next.pattern = pattern_clk;
                if (!locked)
                begin
                    st_next.generator = gen_adv;
                end
                res.value = low_shifted[4:0];
            end
            OP_ADJUST_CHANCE:
                st_next.chance_index = adjust(st.chance_index, delta, CHANCE_MAX);
            OP_ADJUST_LENGTH:
                st_next.length_index = adjust(st.length_index, delta, LENGTH_MAX);
            OP_ADJUST_RANGE:
                st_next.range_index = adjust(st.range_index, delta, RANGE_MAX);
            OP_RESTART:
            begin
                st_next.generator    = mod251(seed);
                st_next.pattern      = 16'd0;
                st_next.chance_index = CHANCE_RESET;
                st_next.length_index = LENGTH_RESET;
                st_next.range_index  = RANGE_RESET;
            end
            default:
            begin
                st_next = st;
            end
        endcase
        res.loop_length = length_of(st_next.length_index);
    end

endmodule

// ===== design/looping_random_shift_sequencer_unit.sv =====
// Top level of the looping random shift sequencer: state, seed register and output queue.
// Each input transfer's result is registered in the output register, or in the skid register while the output stalls.
// Throughput is one item per cycle; while the output stalls, the two-entry output queue takes
// one more transfer and then holds the input until a result leaves.
// Reset clears the seed, generator and pattern and sets the knob indices to 1, 6 and 4.
// Depends on lrss_pkg, lrss_step and the assertion macro header.
`include "looping_random_shift_sequencer_unit_defines.svh"
module looping_random_shift_sequencer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] delta
    input  logic [2:0]  s_tuser,   // [2:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [4:0] value, [9:5] loop_length, [15:10] zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lrss_pkg::*;

    state_t     state_reg;
    state_t     state_next;
    result_t    res_new;
    logic [15:0] seed_reg;
    result_t    out_reg;
    result_t    skid_reg;
    logic       out_valid_reg;
    logic       skid_valid_reg;
    logic       push;
    logic       pop;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ADDR_SEED[2]) ? {16'd0, seed_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= 16'd0;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == ADDR_SEED[2])
        begin
            seed_reg <= pwdata[15:0];
        end
    end

    lrss_step u_step (
        .st      (state_reg),
        .op      (s_tuser),
        .delta   (s_tdata),
        .seed    (seed_reg),
        .st_next (state_next),
        .res     (res_new)
    );

    assign s_tready = !skid_valid_reg;
    assign push     = s_tvalid && s_tready;
    assign pop      = out_valid_reg && m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg.loop_length, out_reg.value};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.generator    <= 8'd0;
            state_reg.pattern      <= 16'd0;
            state_reg.chance_index <= CHANCE_RESET;
            state_reg.length_index <= LENGTH_RESET;
            state_reg.range_index  <= RANGE_RESET;
        end
        else if (push)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (pop)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (out_valid_reg)
            begin
                if (push && !pop)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else if (!push && pop)
                begin
                    out_valid_reg <= 1'b0;
                end
            end
            else if (push)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_reg <= res_new;
            end
            else
            begin
                skid_reg <= res_new;
            end
        end
    end

    `LRSS_ASSERT_SAME(a_skid_needs_out, clk, rst_n, skid_valid_reg, out_valid_reg,
        "Output queue holds a skid entry without a head entry.")
    `LRSS_ASSERT_SAME(a_gen_reduced, clk, rst_n, 1'b1, state_reg.generator < GEN_MOD,
        "Generator is not reduced below the modulus.")
    `LRSS_ASSERT_SAME(a_index_bounds, clk, rst_n, 1'b1,
        state_reg.chance_index <= CHANCE_MAX && state_reg.length_index <= LENGTH_MAX
        && state_reg.range_index <= RANGE_MAX,
        "A knob index lies outside its table.")
    `LRSS_ASSERT_NEXT(a_full_pop_frees, clk, rst_n, skid_valid_reg && m_tready,
        out_valid_reg && !skid_valid_reg,
        "Draining a full output queue did not leave exactly one entry.")

endmodule
